### sv/assert_macros.svh
// Assertion macros shared by the scheduler RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check that a condition implies a consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### sv/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Types and constants of the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;
  localparam int MaxTasks = 64;
  localparam int IdW      = 6;
  localparam int CntW     = 7;

  typedef logic [IdW-1:0]  id_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [2:0] {
    CMD_CREATE = 3'd0,
    CMD_FINISH = 3'd1,
    CMD_TICK   = 3'd2,
    CMD_YIELD  = 3'd3,
    CMD_STATUS = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    RC_OK       = 3'd0,
    RC_NO_FREE  = 3'd1,
    RC_NO_CUR   = 3'd2,
    RC_NONE_RDY = 3'd3,
    RC_EMPTY    = 3'd4,
    RC_ABSENT   = 3'd5
  } rc_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_TICK, ST_IDLE_RD, ST_IDLE_WALK,
    ST_SRCH, ST_SHIFT_RD, ST_SHIFT, ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;      // capture the input word
    logic exec;       // perform the command's map and result-code updates
    logic rd_head;    // read ring at head + k
    logic rd_next;    // read ring at head + k + 1
    logic rot;        // move head entry to tail, advance head
    logic k_inc;      // advance walk index
    logic k_clr;      // clear walk index
    logic tick_scan;  // evaluate visited entry during tick
    logic pick_idle;  // take the last rotated entry as pick
    logic sh_wr;      // write shifted entry at head + k
    logic remove_end; // finish removal (shrink ring, maybe reappend)
    logic tick_end;   // finish tick
    logic emit;       // present result
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_t cmd;
    logic found;      // tick found a ready non-idle task
    logic hit;        // search entry matches running id
    logic k_last;     // k + 1 == count
    logic k_end;      // k == count
    logic k_idle;     // k == idle position
    logic has_idle;   // an idle candidate was seen
    logic empty;
    logic run_valid;
  } sts_t;
endpackage

### sv/rrts_ram.sv
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrts_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### sv/rrts_ctrl.sv
// ----------------------------------------------------------------------------
// rrts_ctrl
// Sequencer for the scheduler: walks the ring for tick and removal.
// ----------------------------------------------------------------------------
module rrts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  rrts_pkg::sts_t sts,
  output rrts_pkg::ctl_t ctl,
  output logic          busy
);
  import rrts_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    busy      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.latch = 1'b1;
          ctl.k_clr = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        // Route by command; start ring read at head
        ctl.rd_head = 1'b1;
        if (sts.cmd == CMD_TICK && !sts.empty) begin
          state_nxt = ST_TICK;
        end else if ((sts.cmd == CMD_FINISH || sts.cmd == CMD_YIELD) && sts.run_valid) begin
          ctl.exec  = 1'b1;
          state_nxt = ST_SRCH;
        end else begin
          ctl.exec  = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_TICK: begin
        // Rotate visited entry and test it
        ctl.rot       = 1'b1;
        ctl.tick_scan = 1'b1;
        ctl.k_inc     = 1'b1;
        ctl.rd_next   = 1'b1;
        if (sts.found) begin
          ctl.tick_end = 1'b1;
          state_nxt    = ST_DONE;
        end else if (sts.k_last) begin
          ctl.k_clr = 1'b1;
          state_nxt = ST_IDLE_RD;
        end
      end
      ST_IDLE_RD: begin
        ctl.rd_head = 1'b1;
        if (sts.has_idle) begin
          state_nxt = ST_IDLE_WALK;
        end else begin
          ctl.tick_end = 1'b1;
          state_nxt    = ST_DONE;
        end
      end
      ST_IDLE_WALK: begin
        ctl.rot       = 1'b1;
        ctl.pick_idle = 1'b1;
        ctl.k_inc     = 1'b1;
        ctl.rd_next   = 1'b1;
        if (sts.k_idle) begin
          ctl.tick_end = 1'b1;
          state_nxt    = ST_DONE;
        end
      end
      ST_SRCH: begin
        // Find running id in ring
        if (sts.k_end) begin
          state_nxt = ST_DONE;
        end else if (sts.hit) begin
          state_nxt = ST_SHIFT_RD;
        end else begin
          ctl.k_inc   = 1'b1;
          ctl.rd_next = 1'b1;
        end
      end
      ST_SHIFT_RD: begin
        ctl.rd_next = 1'b1;
        if (sts.k_last) begin
          ctl.remove_end = 1'b1;
          state_nxt      = ST_DONE;
        end else begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        // Pull next entry down one slot
        ctl.sh_wr   = 1'b1;
        ctl.k_inc   = 1'b1;
        state_nxt   = ST_SHIFT_RD;
      end
      ST_DONE: begin
        ctl.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

### sv/rrts_dpath.sv
// ----------------------------------------------------------------------------
// rrts_dpath
// Scheduler state: id map, marks, ring memory, head, count and running task.
// ----------------------------------------------------------------------------
module rrts_dpath (
  input  logic           clk,
  input  logic           rst_n,
  input  rrts_pkg::ctl_t ctl,
  output rrts_pkg::sts_t sts,
  input  logic [2:0]     in_cmd,
  input  logic [5:0]     in_target_id,
  input  logic           in_new_is_idle,
  input  logic           in_new_sleep,
  output logic           out_valid,
  output logic [2:0]     out_result_code,
  output logic [5:0]     out_assigned_id,
  output logic [5:0]     out_current_id,
  output logic           out_current_valid,
  output logic           out_switched,
  output logic           out_timer_stop
);
  import rrts_pkg::*;

  logic [MaxTasks-1:0] used_r, sleep_r, idle_r;
  id_t  head_r, run_id_r, k_id, idle_pos_r, pick_r, asg_r;
  cnt_t count_r, k_r;
  logic run_v_r, has_idle_r, found_r, sw_r, stop_r, valid_r;
  rc_t  code_r;
  cmd_t cmd_r;
  id_t  tgt_r;
  logic nidle_r, nsleep_r;

  // Ring memory ports
  logic ram_we;
  id_t  ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  rrts_ram #(.Width(IdW), .Depth(MaxTasks)) u_ring (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign k_id = k_r[IdW-1:0];

  // Lowest free id
  id_t  free_id;
  logic any_free;
  always_comb begin
    free_id  = '0;
    any_free = 1'b0;
    for (int i = MaxTasks - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_id  = IdW'(i);
        any_free = 1'b1;
      end
    end
  end

  logic ready_rd, idle_rd, found_now;
  assign ready_rd  = !sleep_r[ram_rdata] && !idle_r[ram_rdata];
  assign idle_rd   = !sleep_r[ram_rdata] && idle_r[ram_rdata];
  assign found_now = ctl.tick_scan && ready_rd;

  // Memory addressing and writes
  always_comb begin
    ram_raddr = head_r + k_id;
    if (ctl.rd_next) ram_raddr = head_r + k_id + IdW'(1);
    // While rotating, the next entry to visit sits at the new head
    if (ctl.rot) ram_raddr = head_r + IdW'(1);
    ram_we    = 1'b0;
    ram_waddr = head_r + count_r[IdW-1:0];
    ram_wdata = free_id;
    if (ctl.exec && cmd_r == CMD_CREATE && any_free) ram_we = 1'b1;
    if (ctl.rot) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata;
    end
    if (ctl.sh_wr) begin
      ram_we    = 1'b1;
      ram_waddr = head_r + k_id;
      ram_wdata = ram_rdata;
    end
    if (ctl.remove_end && cmd_r == CMD_YIELD) begin
      ram_we    = 1'b1;
      ram_waddr = head_r + count_r[IdW-1:0] - IdW'(1);
      ram_wdata = run_id_r;
    end
  end

  // Status to controller
  always_comb begin
    sts.cmd       = cmd_r;
    sts.found     = found_now;
    sts.hit       = (ram_rdata == run_id_r);
    sts.k_last    = (k_r + cnt_t'(1) == count_r);
    sts.k_end     = (k_r == count_r);
    sts.k_idle    = (k_id == idle_pos_r);
    sts.has_idle  = has_idle_r;
    sts.empty     = (count_r == '0);
    sts.run_valid = run_v_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0; sleep_r <= '0; idle_r <= '0;
      head_r <= '0; count_r <= '0; run_id_r <= '0; run_v_r <= 1'b0;
      valid_r <= 1'b0; k_r <= '0;
    end else begin
      valid_r <= ctl.emit;
      if (ctl.k_clr) k_r <= '0;
      else if (ctl.k_inc) k_r <= k_r + cnt_t'(1);
      if (ctl.rot) head_r <= head_r + IdW'(1);
      if (ctl.exec) begin
        case (cmd_r)
          CMD_CREATE: if (any_free) begin
            used_r[free_id]  <= 1'b1;
            sleep_r[free_id] <= 1'b0;
            idle_r[free_id]  <= nidle_r;
            count_r          <= count_r + cnt_t'(1);
          end
          CMD_FINISH: if (run_v_r) begin
            used_r[run_id_r]  <= 1'b0;
            sleep_r[run_id_r] <= 1'b0;
            idle_r[run_id_r]  <= 1'b0;
          end
          CMD_YIELD: if (run_v_r) sleep_r[run_id_r] <= nsleep_r;
          CMD_STATUS: if (used_r[tgt_r] && !idle_r[tgt_r]) sleep_r[tgt_r] <= nsleep_r;
          default: ;
        endcase
      end
      if (ctl.remove_end && cmd_r == CMD_FINISH) count_r <= count_r - cnt_t'(1);
      // Drop the running task once the ring search for it is over
      if (ctl.emit && cmd_r == CMD_FINISH) begin
        run_v_r  <= 1'b0;
        run_id_r <= '0;
      end
      if (ctl.tick_end && (found_now || ctl.pick_idle)) begin
        run_v_r  <= 1'b1;
        run_id_r <= found_now ? ram_rdata : ram_rdata;
      end
    end
  end

  // Item and result words
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r <= cmd_t'(in_cmd); tgt_r <= in_target_id;
      nidle_r <= in_new_is_idle; nsleep_r <= in_new_sleep;
      code_r <= RC_OK; asg_r <= '0; sw_r <= 1'b0; stop_r <= 1'b0;
      has_idle_r <= 1'b0; found_r <= 1'b0; idle_pos_r <= '0; pick_r <= '0;
    end
    if (ctl.exec) begin
      case (cmd_r)
        CMD_CREATE: if (any_free) asg_r <= free_id; else code_r <= RC_NO_FREE;
        CMD_FINISH, CMD_YIELD: if (!run_v_r) code_r <= RC_NO_CUR;
        CMD_TICK: begin code_r <= RC_EMPTY; stop_r <= 1'b1; end
        CMD_STATUS: if (!used_r[tgt_r]) code_r <= RC_ABSENT;
        default: ;
      endcase
    end
    if (ctl.tick_scan && idle_rd && !has_idle_r) begin
      has_idle_r <= 1'b1;
      idle_pos_r <= k_id;
    end
    if (ctl.tick_end) begin
      if (found_now || ctl.pick_idle) begin
        sw_r   <= !run_v_r || (run_id_r != ram_rdata);
        pick_r <= ram_rdata;
        found_r <= 1'b1;
      end else begin
        code_r <= RC_NONE_RDY;
      end
    end
  end

  assign out_valid         = valid_r;
  assign out_result_code   = code_r;
  assign out_assigned_id   = asg_r;
  assign out_current_id    = run_v_r ? run_id_r : '0;
  assign out_current_valid = run_v_r;
  assign out_switched      = sw_r && found_r && (pick_r == run_id_r);
  assign out_timer_stop    = stop_r;
endmodule

### sv/round_robin_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_unit
// Round-robin task scheduler: ring of task ids, free-id map, sleep and idle marks.
// ----------------------------------------------------------------------------
// Give one word by raising start while busy is low; the result word appears
// on the out_ ports for one cycle with out_valid and cannot be held off.
// Create, set-status and commands that fail at once skip the ring walk. Tick
// walks the ring memory one entry per cycle, and a second time up to the idle
// entry when only an idle task is ready. Finish and yield search for the
// running task and shift the later entries down. The ring memory gives one
// entry per cycle and holds 64 entries.
`include "assert_macros.svh"
module round_robin_task_scheduler_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_cmd,
  input  logic [5:0] in_target_id,
  input  logic       in_new_is_idle,
  input  logic       in_new_sleep,
  output logic       out_valid,
  output logic [2:0] out_result_code,
  output logic [5:0] out_assigned_id,
  output logic [5:0] out_current_id,
  output logic       out_current_valid,
  output logic       out_switched,
  output logic       out_timer_stop
);
  import rrts_pkg::*;

  ctl_t ctl;
  sts_t sts;

  rrts_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .start(start), .sts(sts),
                    .ctl(ctl), .busy(busy));

  rrts_dpath u_dpath (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_cmd(in_cmd), .in_target_id(in_target_id),
    .in_new_is_idle(in_new_is_idle), .in_new_sleep(in_new_sleep),
    .out_valid(out_valid), .out_result_code(out_result_code),
    .out_assigned_id(out_assigned_id), .out_current_id(out_current_id),
    .out_current_valid(out_current_valid), .out_switched(out_switched),
    .out_timer_stop(out_timer_stop)
  );

  `ASSERT_IMPL(a_stop_code, clk, rst_n, out_valid && out_timer_stop, out_result_code == RC_EMPTY, "timer stop without empty code")
  `ASSERT_IMPL(a_sw_valid, clk, rst_n, out_valid && out_switched, out_current_valid, "switch with no running task")
  `ASSERT_NEXT(a_emit_idle, clk, rst_n, ctl.emit, !busy, "busy after result")
endmodule
